>>> hdl/lse_pkg.sv
// Shared types and codes for the LSB steganography embed/extract block.
// No dependencies; every other file of the block but lse_store imports this package.
`default_nettype none

package lse_pkg;

	// item operation codes
	typedef logic [1:0] op_t;
	localparam op_t OP_LOAD    = 2'd0;
	localparam op_t OP_PIXEL   = 2'd1;
	localparam op_t OP_RESTART = 2'd2;

	localparam logic MODE_EXTRACT = 1'b1;

	localparam int POS_W     = 36;	// stream bit position
	localparam int FOUND_W   = 32;	// decoded header width
	localparam int LEN_REG_W = 11;	// message_length register

	typedef logic [7:0]       chan_t;
	typedef logic [POS_W-1:0] pos_t;

	typedef struct packed {
		op_t   op;
		chan_t msg_byte;
		chan_t in_red;
		chan_t in_green;
		chan_t in_blue;
	} item_t;

	typedef struct packed {
		chan_t              out_red;
		chan_t              out_green;
		chan_t              out_blue;
		chan_t              out_byte;
		logic               byte_valid;
		logic               length_valid;
		logic [FOUND_W-1:0] found_length;
		logic               done_res;
		logic               overflow;
	} res_t;

endpackage

`default_nettype wire

>>> hdl/lse_item_if.sv
// Input channel of the steganography block: valid/ready plus one item.
// Depends on lse_pkg.
`default_nettype none

interface lse_item_if;
	import lse_pkg::*;

	logic  valid;
	logic  ready;
	op_t   op;
	chan_t msg_byte;
	chan_t in_red;
	chan_t in_green;
	chan_t in_blue;

	modport source (output valid, op, msg_byte, in_red, in_green, in_blue, input ready);
	modport sink   (input valid, op, msg_byte, in_red, in_green, in_blue, output ready);
endinterface

`default_nettype wire

>>> hdl/lse_result_if.sv
// Result channel of the steganography block: valid/ready plus one pixel result.
// Depends on lse_pkg.
`default_nettype none

interface lse_result_if;
	import lse_pkg::*;

	logic               valid;
	logic               ready;
	chan_t              out_red;
	chan_t              out_green;
	chan_t              out_blue;
	chan_t              out_byte;
	logic               byte_valid;
	logic               length_valid;
	logic [FOUND_W-1:0] found_length;
	logic               done_res;
	logic               overflow;

	modport source (output valid, out_red, out_green, out_blue, out_byte, byte_valid,
		length_valid, found_length, done_res, overflow, input ready);
	modport sink   (input valid, out_red, out_green, out_blue, out_byte, byte_valid,
		length_valid, found_length, done_res, overflow, output ready);
endinterface

`default_nettype wire

>>> hdl/lse_store.sv
// Message byte store: one write port, two registered read ports.
// A write to an address being read in the same cycle is forwarded.
`default_nettype none

module lse_store #(
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [7:0]    wdata,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output      logic [7:0]    rdata0,
	output      logic [7:0]    rdata1
);
	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata0 <= (we && waddr == raddr0) ? wdata : mem[raddr0];
		rdata1 <= (we && waddr == raddr1) ? wdata : mem[raddr1];
	end

endmodule

`default_nettype wire

>>> hdl/lsb_stego_embed_extract.sv
// LSB steganography embed/extract top level: item and result channels, APB config.
// Depends on lse_pkg, lse_item_if, lse_result_if and lse_store.
`default_nettype none

// Channel   Dir  Handshake                 Carries
// item      in   valid/ready               op, msg_byte, in_red, in_green, in_blue
// result    out  valid/ready               pixel out, out_byte, flags, found_length
// apb       in   psel/penable, pready=1    mode (0x0), message_length (0x4)
//
// One item per cycle while no pixel waits on a held result. An accepted
// pixel passes the input register, then the result register, to the output.
// Loads and restarts give no result and never wait on the result side.
// A pixel waits in the input register only while the result register holds an
// untaken result. The store read ports are addressed from the next bit position,
// so the two bytes a pixel may touch are always waiting in the read registers.
// Reset clears control and counters; the store is not cleared (no clearing pass).

module lsb_stego_embed_extract #(
	parameter int LENGTH_BITS   = 32,
	parameter int MESSAGE_BYTES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lse_item_if.sink         item,
	lse_result_if.source     result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import lse_pkg::*;

	localparam int AW = (MESSAGE_BYTES > 1) ? $clog2(MESSAGE_BYTES) : 1;
	localparam int CW = $clog2(MESSAGE_BYTES + 1);

	localparam logic REG_MODE   = 1'b0;
	localparam logic REG_LENGTH = 1'b1;

	// config registers
	logic                 mode_q;
	logic [LEN_REG_W-1:0] len_q;

	// input register
	logic  valid_s1;
	item_t item_s1;

	// stream state
	logic [CW-1:0]      cnt_q;
	pos_t               pos_q;
	logic [FOUND_W-1:0] ls_q;
	logic [7:0]         bs_q;
	logic               ovf_q;

	// result register
	logic out_valid_q;
	res_t res_q;

	// handshake
	logic out_free, s1_go, pix_go, load_go, restart_go, full, we;

	// store
	logic [AW-1:0] ra0, ra1;
	logic [7:0]    rd0, rd1;
	pos_t          pos_d, byte_idx;

	// datapath
	logic [LEN_REG_W-1:0] n_emb;
	pos_t                 tot_e, tot_x, tot, pos_new;
	logic [FOUND_W-1:0]   ls_new;
	logic [7:0]           bs_new;
	res_t                 res_d;

	//------------------------------------------------------------------
	// APB config port; writes land on the access phase
	//------------------------------------------------------------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
			len_q  <= '0;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[2])
				REG_MODE:   mode_q <= pwdata[0];
				REG_LENGTH: len_q  <= pwdata[LEN_REG_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[2])
			REG_MODE:   prdata = 32'(mode_q);
			REG_LENGTH: prdata = 32'(len_q);
			default:    prdata = '0;
		endcase
	end

	//------------------------------------------------------------------
	// Flow control
	//------------------------------------------------------------------
	assign out_free   = !out_valid_q || result.ready;
	// only pixels produce a result, so only they wait on the result register
	assign s1_go      = valid_s1 && (item_s1.op != OP_PIXEL || out_free);
	assign item.ready = !valid_s1 || s1_go;
	assign pix_go     = s1_go && item_s1.op == OP_PIXEL;
	assign load_go    = s1_go && item_s1.op == OP_LOAD;
	assign restart_go = s1_go && item_s1.op == OP_RESTART;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			item_s1 <= '{op: item.op, msg_byte: item.msg_byte, in_red: item.in_red,
				in_green: item.in_green, in_blue: item.in_blue};
		end
	end

	//------------------------------------------------------------------
	// Message store; loads append at the fill count, full loads are dropped
	//------------------------------------------------------------------
	assign full = cnt_q >= CW'(MESSAGE_BYTES);
	assign we   = load_go && !full;

	// next position chooses the byte pair the following pixel may need
	assign pos_d = restart_go ? '0 : (pix_go ? pos_new : pos_q);

	always_comb begin
		byte_idx = (pos_d >= POS_W'(LENGTH_BITS)) ?
			((pos_d - POS_W'(LENGTH_BITS)) >> 3) : '0;
		ra0 = (byte_idx < POS_W'(MESSAGE_BYTES)) ? byte_idx[AW-1:0] : '0;
		// past the last entry the second byte is never embedded
		ra1 = (byte_idx + POS_W'(1) < POS_W'(MESSAGE_BYTES)) ?
			AW'(byte_idx + POS_W'(1)) : ra0;
	end

	lse_store #(
		.DEPTH (MESSAGE_BYTES)
	) u_store (
		.clk    (clk),
		.we     (we),
		.waddr  (cnt_q[AW-1:0]),
		.wdata  (item_s1.msg_byte),
		.raddr0 (ra0),
		.raddr1 (ra1),
		.rdata0 (rd0),
		.rdata1 (rd1)
	);

	//------------------------------------------------------------------
	// Pixel datapath: three bits, green then blue then red
	//------------------------------------------------------------------
	always_comb begin
		chan_t      ch [3];
		chan_t      ch_o [3];
		pos_t       p [3];
		logic       hdr [3];
		logic       take [3];
		logic       ebit;
		logic [2:0] d;
		logic [2:0] k;
		logic [3:0] wi;
		logic [15:0] win;
		logic [1:0] cnt;
		logic       past_hdr;
		logic [7:0] obyte;
		logic       bvalid;
		logic       lvalid;
		logic       is_x;

		ch[0]    = item_s1.in_green;
		ch[1]    = item_s1.in_blue;
		ch[2]    = item_s1.in_red;
		is_x     = mode_q == MODE_EXTRACT;
		win      = {rd1, rd0};
		d        = pos_q[2:0] - 3'(LENGTH_BITS);	// (pos - header) mod 8
		past_hdr = pos_q >= POS_W'(LENGTH_BITS);

		// byte count saturates at the store depth
		n_emb = (32'(len_q) < 32'(MESSAGE_BYTES)) ? len_q : LEN_REG_W'(MESSAGE_BYTES);
		tot_e = POS_W'(LENGTH_BITS) + POS_W'({n_emb, 3'b000});

		for (int j = 0; j < 3; j++) begin
			p[j]   = pos_q + POS_W'(j);
			hdr[j] = p[j] < POS_W'(LENGTH_BITS);
		end

		// header bits of this pixel enter the length before the body limit is known
		ls_new = ls_q;
		for (int j = 0; j < 3; j++) begin
			if (hdr[j] && p[j] < POS_W'(FOUND_W)) begin
				ls_new[p[j][4:0]] = ls_new[p[j][4:0]] | ch[j][0];
			end
		end
		tot_x = POS_W'(LENGTH_BITS) + POS_W'({ls_new, 3'b000});
		tot   = is_x ? tot_x : tot_e;

		// bits are taken in order up to the stream end
		cnt = '0;
		for (int j = 0; j < 3; j++) begin
			take[j] = p[j] < tot;
			cnt     = cnt + 2'(take[j]);
		end
		pos_new = pos_q + POS_W'(cnt);

		// embed: set or clear each taken LSB
		for (int j = 0; j < 3; j++) begin
			wi = past_hdr ? ({1'b0, d} + 4'(j)) : {1'b0, 3'(d + 3'(j))};
			if (hdr[j]) begin
				ebit = (p[j] < POS_W'(LEN_REG_W)) ? n_emb[p[j][3:0]] : 1'b0;
			end else begin
				ebit = win[wi];
			end
			ch_o[j] = (take[j] && !is_x) ? {ch[j][7:1], ebit} : ch[j];
		end

		// extract: collect body bits, at most one byte completes per pixel
		bs_new = bs_q;
		obyte  = '0;
		bvalid = 1'b0;
		lvalid = 1'b0;
		for (int j = 0; j < 3; j++) begin
			k = 3'(d + 3'(j));
			if (take[j] && hdr[j] && p[j] == POS_W'(LENGTH_BITS - 1)) begin
				lvalid = 1'b1;
			end
			if (take[j] && !hdr[j]) begin
				bs_new[k] = bs_new[k] | ch[j][0];
				if (k == 3'd7) begin
					obyte  = bs_new;
					bvalid = 1'b1;
					bs_new = '0;
				end
			end
		end

		res_d.out_red      = ch_o[2];
		res_d.out_green    = ch_o[0];
		res_d.out_blue     = ch_o[1];
		res_d.out_byte     = is_x ? obyte : '0;
		res_d.byte_valid   = is_x && bvalid;
		res_d.length_valid = is_x && lvalid;
		res_d.found_length = (is_x && pos_new >= POS_W'(LENGTH_BITS)) ? ls_new : '0;
		res_d.done_res     = is_x ? (pos_new >= POS_W'(LENGTH_BITS) && pos_new >= tot_x)
			: (pos_new >= tot_e);
		res_d.overflow     = ovf_q;
	end

	//------------------------------------------------------------------
	// Stream state
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			pos_q <= '0;
			ls_q  <= '0;
			bs_q  <= '0;
			ovf_q <= 1'b0;
		end else if (restart_go) begin
			cnt_q <= '0;
			pos_q <= '0;
			ls_q  <= '0;
			bs_q  <= '0;
			ovf_q <= 1'b0;
		end else if (load_go) begin
			if (full) begin
				ovf_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q + CW'(1);
			end
		end else if (pix_go) begin
			pos_q <= pos_new;
			if (mode_q == MODE_EXTRACT) begin
				ls_q <= ls_new;
				bs_q <= bs_new;
			end
		end
	end

	//------------------------------------------------------------------
	// Result register
	//------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pix_go) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_go) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = out_valid_q;
	assign result.out_red      = res_q.out_red;
	assign result.out_green    = res_q.out_green;
	assign result.out_blue     = res_q.out_blue;
	assign result.out_byte     = res_q.out_byte;
	assign result.byte_valid   = res_q.byte_valid;
	assign result.length_valid = res_q.length_valid;
	assign result.found_length = res_q.found_length;
	assign result.done_res     = res_q.done_res;
	assign result.overflow     = res_q.overflow;

	//------------------------------------------------------------------
	// Checks
	//------------------------------------------------------------------
	// a pixel moves the position by three bits at most
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(restart_go) |-> (pos_q - $past(pos_q)) <= POS_W'(3))
		else $error("bit position jumped");

	// fill count never passes the store depth
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MESSAGE_BYTES))
		else $error("fill count beyond store depth");

	// a held result freezes the stream position
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready && valid_s1 && item_s1.op == OP_PIXEL)
		|=> $stable(pos_q))
		else $error("pixel processed while result stalled");

	// overflow rises only on a load against a full store
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ovf_q) |-> $past(load_go && full))
		else $error("overflow set without a dropped load");

endmodule

`default_nettype wire

>>> sim/lse_tb_pkg.sv
`timescale 1ns / 1ps
// Testbench constants for the LSB steganography block: register map, unused op, sizes.
// Depends on lse_pkg.

package lse_tb_pkg;
	import lse_pkg::*;

	localparam op_t OP_UNUSED = 2'd3;	// no effect, no result

	localparam logic [2:0] ADDR_MODE    = 3'd0;
	localparam logic [2:0] ADDR_MSG_LEN = 3'd4;

	localparam int HEADER_BITS = 32;
	localparam int STORE_DEPTH = 1024;
endpackage

>>> sim/lse_stego_check.sv
`timescale 1ns / 1ps
// Watches the item, result and APB channels of lsb_stego_embed_extract, predicts each
// pixel result and compares it field by field. Depends on lse_pkg, lse_tb_pkg, interfaces.

module lse_stego_check (
	input  wire logic        clk,
	input  wire logic        arst_n,
	lse_item_if              item,
	lse_result_if            result,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic        pready,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output int               mismatches,
	output int               pending
);
	import lse_pkg::*;
	import lse_tb_pkg::*;

	chan_t                msg_store [STORE_DEPTH];
	int                   stored_count;
	pos_t                 stream_pos;
	logic [31:0]          hdr_shift;
	chan_t                byte_acc;
	logic                 ovf_flag;
	logic                 cfg_mode;
	logic [LEN_REG_W-1:0] cfg_len;
	res_t                 pixel_results [$];
	res_t                 exp_r;
	int                   err_count = 0;

	// end of the extracted stream as far as the decoded header says
	function automatic pos_t extract_end();
		return pos_t'(HEADER_BITS) + (pos_t'(hdr_shift) << 3);
	endfunction

	function automatic logic embed_bit(pos_t p, logic [31:0] n);
		if (p < HEADER_BITS)
			return n[p[4:0]];
		return msg_store[int'((p - HEADER_BITS) >> 3)][p[2:0]];
	endfunction

	function automatic res_t process_pixel(chan_t red, chan_t green, chan_t blue);
		chan_t                ch [3];
		res_t                 r;
		pos_t                 total;
		logic [LEN_REG_W-1:0] n;
		logic                 b;
		logic [2:0]           k;
		r = '0;
		ch[0] = green;
		ch[1] = blue;
		ch[2] = red;
		if (cfg_mode != MODE_EXTRACT) begin
			n = (cfg_len < STORE_DEPTH) ? cfg_len : LEN_REG_W'(STORE_DEPTH);
			total = pos_t'(HEADER_BITS) + (pos_t'(n) << 3);
			for (int i = 0; i < 3; i++) begin
				if (stream_pos < total) begin
					ch[i][0] = embed_bit(stream_pos, 32'(n));
					stream_pos++;
				end
			end
			r.done_res = (stream_pos >= total);
		end else begin
			for (int i = 0; i < 3; i++) begin
				b = ch[i][0];
				if (stream_pos < HEADER_BITS) begin
					if (b)
						hdr_shift[stream_pos[4:0]] = 1'b1;
					stream_pos++;
					if (stream_pos == HEADER_BITS)
						r.length_valid = 1'b1;
				end else if (stream_pos < extract_end()) begin
					k = 3'(stream_pos - HEADER_BITS);
					if (b)
						byte_acc[k] = 1'b1;
					stream_pos++;
					if (k == 3'd7) begin
						r.out_byte   = byte_acc;
						r.byte_valid = 1'b1;
						byte_acc     = '0;
					end
				end
			end
			if (stream_pos >= HEADER_BITS) begin
				r.found_length = hdr_shift;
				r.done_res     = (stream_pos >= extract_end());
			end
		end
		r.out_red   = ch[2];
		r.out_green = ch[0];
		r.out_blue  = ch[1];
		r.overflow  = ovf_flag;
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] expv, logic [63:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s expected %0h, actual %0h", $time, name, expv, actv);
			err_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count = 0;
			stream_pos   = '0;
			hdr_shift    = '0;
			byte_acc     = '0;
			ovf_flag     = 1'b0;
			cfg_mode     = 1'b0;
			cfg_len      = '0;
			pixel_results.delete();
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr)
					ADDR_MODE:    cfg_mode = pwdata[0];
					ADDR_MSG_LEN: cfg_len  = pwdata[LEN_REG_W-1:0];
					default: ;
				endcase
			end

			if (result.valid && result.ready) begin
				if (pixel_results.size() == 0) begin
					$display("%0t: result transfer with no pixel waiting, actual %0h %0h %0h",
						$time, result.out_red, result.out_green, result.out_blue);
					err_count++;
				end else begin
					exp_r = pixel_results.pop_front();
					compare_field("out_red", exp_r.out_red, result.out_red);
					compare_field("out_green", exp_r.out_green, result.out_green);
					compare_field("out_blue", exp_r.out_blue, result.out_blue);
					compare_field("out_byte", exp_r.out_byte, result.out_byte);
					compare_field("byte_valid", exp_r.byte_valid, result.byte_valid);
					compare_field("length_valid", exp_r.length_valid, result.length_valid);
					compare_field("found_length", exp_r.found_length, result.found_length);
					compare_field("done_res", exp_r.done_res, result.done_res);
					compare_field("overflow", exp_r.overflow, result.overflow);
				end
			end

			if (item.valid && item.ready) begin
				case (item.op)
					OP_LOAD: begin
						if (stored_count < STORE_DEPTH) begin
							msg_store[stored_count] = item.msg_byte;
							stored_count++;
						end else begin
							ovf_flag = 1'b1;
						end
					end
					OP_PIXEL: pixel_results.insert(pixel_results.size(),
						process_pixel(item.in_red, item.in_green, item.in_blue));
					OP_RESTART: begin
						stream_pos   = '0;
						hdr_shift    = '0;
						byte_acc     = '0;
						stored_count = 0;
						ovf_flag     = 1'b0;
					end
					default: ;
				endcase
			end
			pending <= pixel_results.size();
		end
	end

	always @(posedge clk)
		mismatches <= err_count;

endmodule

>>> sim/lsb_stego_embed_extract_tb.sv
`timescale 1ns / 1ps
// Top of the lsb_stego_embed_extract testbench: clock, reset, APB setup, directed and
// random item streams with random stalls. Depends on lse_pkg, lse_tb_pkg, lse_stego_check.

module lsb_stego_embed_extract_tb;
	import lse_pkg::*;
	import lse_tb_pkg::*;

	localparam int ITEM_TARGET   = 1750;
	localparam int CYCLE_LIMIT   = 400000;
	localparam int SETTLE_CYCLES = 4;	// input reg + result reg, plus margin
	localparam int MAX_PIXELS    = 60;	// keeps long headers from dominating the run

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending;
	int items_sent = 0;
	int cycles     = 0;
	int send_style = 0;	// 0 back to back, 1 full random gaps, 2 rare gaps
	int recv_style = 0;
	int embed_sessions   = 0;
	int extract_sessions = 0;

	always #5 clk = ~clk;

	lse_item_if   item_ch ();
	lse_result_if result_ch ();

	lsb_stego_embed_extract #(
		.LENGTH_BITS   (HEADER_BITS),
		.MESSAGE_BYTES (STORE_DEPTH)
	) i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	lse_stego_check u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.pready     (pready),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// hard stop in case a handshake never completes
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("lsb_stego_embed_extract_tb failed");
			$finish;
		end
	end

	function automatic int draw_gap(int style);
		case (style)
			0:       return 0;
			1:       return $urandom_range(0, 19);
			default: return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 19) : 0;
		endcase
	endfunction

	// channel values lean on the extremes so the LSB set/clear is hit from both sides
	function automatic chan_t rand_chan();
		case ($urandom_range(0, 7))
			0:       return 8'h00;
			1:       return 8'hFF;
			default: return chan_t'($urandom);
		endcase
	endfunction

	function automatic item_t noise_item(op_t op);
		item_t it;
		it.op       = op;
		it.msg_byte = chan_t'($urandom);
		it.in_red   = rand_chan();
		it.in_green = rand_chan();
		it.in_blue  = rand_chan();
		return it;
	endfunction

	// Pixel whose LSBs carry header bits at stream offset bit_idx (green, blue, red);
	// past the header, or when not well formed, the LSBs stay random.
	function automatic item_t pixel_item(int bit_idx, logic [31:0] hdr, bit well_formed);
		item_t it;
		it = noise_item(OP_PIXEL);
		if (well_formed) begin
			if (bit_idx < HEADER_BITS)
				it.in_green[0] = hdr[bit_idx];
			if (bit_idx + 1 < HEADER_BITS)
				it.in_blue[0] = hdr[bit_idx + 1];
			if (bit_idx + 2 < HEADER_BITS)
				it.in_red[0] = hdr[bit_idx + 2];
		end
		return it;
	endfunction

	// One transfer on the item channel; valid stays high into the next item when
	// the drawn gap is zero.
	task automatic send_item(item_t it);
		int gap;
		gap = draw_gap(send_style);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid    <= 1'b1;
		item_ch.op       <= it.op;
		item_ch.msg_byte <= it.msg_byte;
		item_ch.in_red   <= it.in_red;
		item_ch.in_green <= it.in_green;
		item_ch.in_blue  <= it.in_blue;
		@(posedge clk);
		while (!item_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// Drain: every predicted pixel has come back, then let trailing loads and
	// restarts clear the pipeline.
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// setup and access phase, then psel is dropped so writes never abut
	task automatic apb_write(logic [2:0] addr, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// register writes only on an idle block; idling styles change here too
	task automatic configure(logic m, logic [LEN_REG_W-1:0] len);
		wait_idle();
		apb_write(ADDR_MODE, 32'(m));
		apb_write(ADDR_MSG_LEN, 32'(len));
		send_style = $urandom_range(0, 2);
		recv_style = $urandom_range(0, 2);
	endtask

	// Restart, then a stream long enough to finish (capped), sprinkled with loads,
	// unused ops and the odd restart. Optionally flips the mode halfway through.
	task automatic stream_session(logic m, logic [LEN_REG_W-1:0] len, logic [31:0] hdr,
			bit flip_mid);
		longint total_bits;
		int     embed_bytes;
		int     n_pix;
		int     pix;
		int     bit_idx;
		int     r;
		logic   cur_mode;
		bit     flipped;
		configure(m, len);
		cur_mode    = m;
		flipped     = 1'b0;
		bit_idx     = 0;
		pix         = 0;
		embed_bytes = (len > STORE_DEPTH) ? STORE_DEPTH : int'(len);
		total_bits  = (m == MODE_EXTRACT) ? HEADER_BITS + 8 * longint'(hdr)
			: HEADER_BITS + 8 * longint'(embed_bytes);
		total_bits  = (total_bits + 2) / 3 + $urandom_range(0, 3);
		n_pix       = (total_bits > MAX_PIXELS) ? MAX_PIXELS : int'(total_bits);
		send_item(noise_item(OP_RESTART));
		while (pix < n_pix) begin
			if (flip_mid && !flipped && pix == n_pix / 2) begin
				// both modes share the bit position, so the stream just carries on
				configure(!cur_mode, len);
				cur_mode = !cur_mode;
				flipped  = 1'b1;
			end
			r = $urandom_range(0, 99);
			if (r < 7) begin
				send_item(noise_item(OP_LOAD));
			end else if (r < 10) begin
				send_item(noise_item(OP_UNUSED));
			end else if (r < 12) begin
				send_item(noise_item(OP_RESTART));
				bit_idx = 0;
			end else begin
				send_item(pixel_item(bit_idx, hdr, $urandom_range(0, 9) != 0));
				bit_idx += 3;
				pix++;
			end
		end
	endtask

	// result side: random stall before each transfer, none in some stretches
	initial begin
		int gap;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			gap = draw_gap(recv_style);
			if (gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			@(posedge clk);
			while (!result_ch.valid) @(posedge clk);
		end
	end

	initial begin
		item_t                it;
		int                   loaded;
		int                   pix;
		int                   hb;
		logic                 m;
		logic [LEN_REG_W-1:0] len;
		logic [31:0]          hdr;

		item_ch.valid    <= 1'b0;
		item_ch.op       <= OP_LOAD;
		item_ch.msg_byte <= '0;
		item_ch.in_red   <= '0;
		item_ch.in_green <= '0;
		item_ch.in_blue  <= '0;
		psel             <= 1'b0;
		penable          <= 1'b0;
		pwrite           <= 1'b0;
		paddr            <= '0;
		pwdata           <= '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: embed a one-byte message over all-zero, all-ones and random pixels, one
		// pixel past done (pass-through), an unused op, then a restart.
		configure(1'b0, LEN_REG_W'(1));
		it = noise_item(OP_LOAD);
		it.msg_byte = 8'hFF;
		send_item(it);
		it.msg_byte = 8'h00;
		send_item(it);
		for (int i = 0; i < 15; i++) begin
			it = noise_item(OP_PIXEL);
			case (i % 3)
				0: begin
					it.in_red   = 8'h00;
					it.in_green = 8'h00;
					it.in_blue  = 8'h00;
				end
				1: begin
					it.in_red   = 8'hFF;
					it.in_green = 8'hFF;
					it.in_blue  = 8'hFF;
				end
				default: ;
			endcase
			send_item(it);
		end
		send_item(noise_item(OP_UNUSED));
		send_item(noise_item(OP_RESTART));

		// Fill the whole store and run past it (store full, sticky overflow) while
		// embedding with an oversized length register. Pixels only go out once the
		// bytes they read have been loaded.
		configure(1'b0, {LEN_REG_W{1'b1}});
		loaded = 0;
		pix    = 0;
		while (loaded < STORE_DEPTH + 2) begin
			hb = 3 * pix + 2;
			if ((hb < HEADER_BITS || (hb - HEADER_BITS) / 8 < loaded)
					&& $urandom_range(0, 7) == 0) begin
				send_item(noise_item(OP_PIXEL));
				pix++;
			end else begin
				send_item(noise_item(OP_LOAD));
				loaded++;
			end
		end
		repeat (3) send_item(noise_item(OP_PIXEL));

		// Random sessions; every store entry is written from here on.
		while (items_sent < ITEM_TARGET) begin
			m = 1'($urandom_range(0, 1));
			if (m == MODE_EXTRACT) begin
				len = LEN_REG_W'($urandom_range(0, 2047));
				case (extract_sessions)
					0:       hdr = '0;
					1:       hdr = '1;
					default: hdr = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 12) : $urandom;
				endcase
				extract_sessions++;
			end else begin
				hdr = $urandom_range(0, 12);
				case (embed_sessions)
					0:       len = '0;
					1:       len = LEN_REG_W'(STORE_DEPTH);
					default: begin
						r_len: case ($urandom_range(0, 9))
							7:       len = '1;
							8, 9:    len = LEN_REG_W'($urandom_range(0, 2047));
							default: len = LEN_REG_W'($urandom_range(0, 12));
						endcase
					end
				endcase
				embed_sessions++;
			end
			stream_session(m, len, hdr, $urandom_range(0, 4) == 0);
		end

		wait_idle();
		if (mismatches == 0) begin
			$display("lsb_stego_embed_extract_tb passed");
		end else begin
			$display("lsb_stego_embed_extract_tb failed");
		end
		$finish;
	end

endmodule

>>> files.f
hdl/lse_pkg.sv
hdl/lse_item_if.sv
hdl/lse_result_if.sv
hdl/lse_store.sv
hdl/lsb_stego_embed_extract.sv
sim/lse_tb_pkg.sv
sim/lse_stego_check.sv
sim/lsb_stego_embed_extract_tb.sv
